### rtl/core/rbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbm_pkg: shared types and constants of the ROM bank mapper
// Source codes, access opcodes, address constants and the result word type.
// ----------------------------------------------------------------------------
package rbm_pkg;

  // Default width of the ROM bank register
  localparam int unsigned RomBankBitsDef = 7;
  // Working width of the bank arithmetic (low five bits plus two upper bits)
  localparam int unsigned BankWorkW      = 7;
  // Width of the translated ROM byte address
  localparam int unsigned RomAddrW       = 21;
  // Offset bits inside one 16 KiB bank
  localparam int unsigned BankOffW       = 14;

  // Overlay disable register address
  localparam logic [15:0] BootOffAddr = 16'hFF50;
  // RAM enable key in the low nibble
  localparam logic [3:0]  RamEnKey    = 4'hA;

  // Access opcode
  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // Register window selected by address bits 14:13 below 0x8000
  localparam logic [1:0] WinRamEn   = 2'd0;
  localparam logic [1:0] WinRomBank = 2'd1;
  localparam logic [1:0] WinUpper   = 2'd2;
  localparam logic [1:0] WinMode    = 2'd3;

  // Read source
  typedef enum logic [1:0] {
    SRC_BOOT  = 2'd0,
    SRC_CART  = 2'd1,
    SRC_OTHER = 2'd2
  } src_e;

  // Result word handed from the decode to the output register
  typedef struct packed {
    src_e                  source;
    logic [RomAddrW-1:0]   rom_addr;
    logic                  ram_enabled;
    logic [1:0]            ram_bank_sel;
    logic                  mode_sel;
  } result_t;

endpackage

### rtl/core/rbm_bank_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbm_bank_ctrl: bank registers and access decode
// Holds the cartridge bank state and the boot overlay flag, updates them on
// each accepted write and forms the result word of the access.
// ----------------------------------------------------------------------------
module rbm_bank_ctrl #(
  parameter int unsigned RomBankBits = rbm_pkg::RomBankBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic             opcode_i,
  input  logic [15:0]      cpu_addr_i,
  input  logic [7:0]       write_data_i,
  output rbm_pkg::result_t result_o
);

  logic [RomBankBits-1:0] rom_bank_q, rom_bank_d;
  logic                   ram_en_q, ram_en_d;
  logic [1:0]             ram_bank_q, ram_bank_d;
  logic                   mode_q, mode_d;
  logic                   boot_q, boot_d;

  logic [rbm_pkg::BankWorkW-1:0] bank_w;

  // Update bank state for a write
  always_comb begin
    bank_w     = rbm_pkg::BankWorkW'(rom_bank_q);
    ram_en_d   = ram_en_q;
    ram_bank_d = ram_bank_q;
    mode_d     = mode_q;
    boot_d     = boot_q;
    if (fire_i && opcode_i == rbm_pkg::OpWrite) begin
      if (cpu_addr_i == rbm_pkg::BootOffAddr) begin
        boot_d = 1'b0;
      end
      if (!cpu_addr_i[15]) begin
        case (cpu_addr_i[14:13])
          rbm_pkg::WinRamEn: begin
            ram_en_d = (write_data_i[3:0] == rbm_pkg::RamEnKey);
          end
          rbm_pkg::WinRomBank: begin
            bank_w[4:0] = write_data_i[4:0];
          end
          rbm_pkg::WinUpper: begin
            if (mode_q) begin
              ram_bank_d = write_data_i[1:0];
            end else begin
              bank_w[6:5] = write_data_i[1:0];
            end
          end
          rbm_pkg::WinMode: begin
            mode_d = write_data_i[0];
          end
          default: begin
            mode_d = mode_q;
          end
        endcase
        // bump banks 0x00, 0x20, 0x40 and 0x60
        bank_w = rbm_pkg::BankWorkW'(RomBankBits'(bank_w));
        if (bank_w[4:0] == 5'd0) begin
          bank_w = bank_w + rbm_pkg::BankWorkW'(1);
        end
      end
    end
    rom_bank_d = RomBankBits'(bank_w);
  end

  // Form the result word
  always_comb begin
    result_o.source       = rbm_pkg::SRC_OTHER;
    result_o.rom_addr     = '0;
    result_o.ram_enabled  = ram_en_d;
    result_o.ram_bank_sel = ram_bank_d;
    result_o.mode_sel     = mode_d;
    if (opcode_i == rbm_pkg::OpRead) begin
      if (boot_q && cpu_addr_i[15:8] == 8'd0) begin
        result_o.source   = rbm_pkg::SRC_BOOT;
        result_o.rom_addr = rbm_pkg::RomAddrW'(cpu_addr_i);
      end else if (cpu_addr_i[15:14] == 2'd0) begin
        result_o.source   = rbm_pkg::SRC_CART;
        result_o.rom_addr = rbm_pkg::RomAddrW'(cpu_addr_i);
      end else if (cpu_addr_i[15:14] == 2'd1) begin
        result_o.source   = rbm_pkg::SRC_CART;
        result_o.rom_addr = (rbm_pkg::RomAddrW'(rom_bank_q) << rbm_pkg::BankOffW)
                          | rbm_pkg::RomAddrW'(cpu_addr_i[rbm_pkg::BankOffW-1:0]);
      end
    end
  end

  // Hold bank state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_bank_q <= RomBankBits'(1);
      ram_en_q   <= 1'b0;
      ram_bank_q <= 2'd0;
      mode_q     <= 1'b0;
      boot_q     <= 1'b1;
    end else begin
      rom_bank_q <= rom_bank_d;
      ram_en_q   <= ram_en_d;
      ram_bank_q <= ram_bank_d;
      mode_q     <= mode_d;
      boot_q     <= boot_d;
    end
  end

  // Low five bank bits never select bank zero of a group
  a_bank_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rom_bank_q[4:0] != 5'd0)
    else $error("ROM bank low bits are zero");

  // Overlay stays off once ended
  a_boot_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !boot_q |=> !boot_q)
    else $error("boot overlay re-armed");

  // Writes never report a ROM source
  a_write_other: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (opcode_i == rbm_pkg::OpWrite) |->
      (result_o.source == rbm_pkg::SRC_OTHER && result_o.rom_addr == '0))
    else $error("write reported a ROM source");

endmodule

### rtl/core/rbm_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbm_out_reg: result register
// Holds one result word and presents it on the output channel until taken.
// ----------------------------------------------------------------------------
module rbm_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rbm_pkg::result_t result_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rbm_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  rbm_pkg::result_t data_q;
  logic             load;

  // Stall upstream only while a held word is blocked
  assign in_stall_o = valid_q && out_stall_i;
  assign load       = in_valid_i && !in_stall_o;

  // Advance valid: fill on load, drop when taken
  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the word on load
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

  // An accepted word is presented next cycle
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> valid_q)
    else $error("accepted word not presented");

  // A blocked word is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_stall_i) |-> !load)
    else $error("held word overwritten");

endmodule

### rtl/core/rom_bank_mapper_with_boot_overlay_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rom_bank_mapper_with_boot_overlay_core: cartridge bank mapper, boot overlay
// Output: the result word of an access is registered and presented in the cycle after accept.
// Throughput: one access word per cycle; the single result register sets it.
// Input stalls only while a presented result is stalled downstream.
// Reset: ROM bank 1, RAM disabled, RAM bank 0, mode 0, boot overlay active.
// ----------------------------------------------------------------------------
module rom_bank_mapper_with_boot_overlay_core #(
  parameter int unsigned RomBankBits = rbm_pkg::RomBankBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [15:0] cpu_addr_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  source_o,
  output logic [rbm_pkg::RomAddrW-1:0] rom_addr_o,
  output logic        ram_enabled_o,
  output logic [1:0]  ram_bank_sel_o,
  output logic        mode_sel_o
);

  rbm_pkg::result_t result, result_q;
  logic             fire;

  assign fire = in_valid_i && !in_stall_o;

  // Decode the access and update bank state
  rbm_bank_ctrl #(
    .RomBankBits(RomBankBits)
  ) u_bank_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .opcode_i    (opcode_i),
    .cpu_addr_i  (cpu_addr_i),
    .write_data_i(write_data_i),
    .result_o    (result)
  );

  // Register the result word
  rbm_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .result_i   (result),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .result_o   (result_q)
  );

  assign source_o       = 2'(result_q.source);
  assign rom_addr_o     = result_q.rom_addr;
  assign ram_enabled_o  = result_q.ram_enabled;
  assign ram_bank_sel_o = result_q.ram_bank_sel;
  assign mode_sel_o     = result_q.mode_sel;

endmodule

### dv/rom_bank_mapper_with_boot_overlay_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rom_bank_mapper_with_boot_overlay_core_tb: bank mapper and boot overlay test
// Sends CPU bus access words through the valid/stall input and keeps its own
// model of the bank registers and the overlay flag. Each result word is checked
// field by field against the oldest predicted word. Directed register and decode
// cases bracket the random bus traffic of the first of three idle profiles.
// ----------------------------------------------------------------------------
module rom_bank_mapper_with_boot_overlay_core_tb;

  localparam int CycleLimit = 200000;
  localparam int ShownErrors = 10;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic                         opcode_i = rbm_pkg::OpRead;
  logic [15:0]                  cpu_addr_i = '0;
  logic [7:0]                   write_data_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [1:0]                   source_o;
  logic [rbm_pkg::RomAddrW-1:0] rom_addr_o;
  logic                         ram_enabled_o;
  logic [1:0]                   ram_bank_sel_o;
  logic                         mode_sel_o;

  // Mapper state as seen by the predictor
  logic [rbm_pkg::BankWorkW-1:0] rom_bank_q;
  logic                          ram_en_q;
  logic [1:0]                    ram_bank_q;
  logic                          mode_q;
  logic                          boot_on_q;

  rbm_pkg::result_t mapped_q[$];
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  int      words_sent = 0;
  int      words_checked = 0;
  int      err_count = 0;
  int      cycles = 0;

  rom_bank_mapper_with_boot_overlay_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .cpu_addr_i     (cpu_addr_i),
    .write_data_i   (write_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .source_o       (source_o),
    .rom_addr_o     (rom_addr_o),
    .ram_enabled_o  (ram_enabled_o),
    .ram_bank_sel_o (ram_bank_sel_o),
    .mode_sel_o     (mode_sel_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stall the result side at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Reset the predicted mapper state
  task automatic reset_mapper();
    rom_bank_q = 7'd1;
    ram_en_q   = 1'b0;
    ram_bank_q = 2'd0;
    mode_q     = 1'b0;
    boot_on_q  = 1'b1;
  endtask

  // Apply one bus access to the predicted state and return its result word
  function automatic rbm_pkg::result_t map_access(logic op, logic [15:0] addr,
                                                  logic [7:0] data);
    rbm_pkg::result_t              r;
    logic [rbm_pkg::BankWorkW-1:0] bank;
    r.source   = rbm_pkg::SRC_OTHER;
    r.rom_addr = '0;
    if (op == rbm_pkg::OpWrite) begin
      if (addr == rbm_pkg::BootOffAddr) boot_on_q = 1'b0;
      if (!addr[15]) begin
        bank = rom_bank_q;
        case (addr[14:13])
          rbm_pkg::WinRamEn:   ram_en_q = (data[3:0] == rbm_pkg::RamEnKey);
          rbm_pkg::WinRomBank: bank[4:0] = data[4:0];
          rbm_pkg::WinUpper: begin
            if (mode_q) ram_bank_q = data[1:0];
            else bank[6:5] = data[1:0];
          end
          rbm_pkg::WinMode:    mode_q = data[0];
          default:             mode_q = mode_q;
        endcase
        // Bank numbers with zero low bits map to the next bank
        if (bank[4:0] == 5'd0) bank = bank + rbm_pkg::BankWorkW'(1);
        rom_bank_q = bank;
      end
    end else begin
      if (boot_on_q && addr <= 16'h00FF) begin
        r.source   = rbm_pkg::SRC_BOOT;
        r.rom_addr = rbm_pkg::RomAddrW'(addr);
      end else if (addr < 16'h4000) begin
        r.source   = rbm_pkg::SRC_CART;
        r.rom_addr = rbm_pkg::RomAddrW'(addr);
      end else if (addr < 16'h8000) begin
        r.source   = rbm_pkg::SRC_CART;
        r.rom_addr = {rom_bank_q, addr[rbm_pkg::BankOffW-1:0]};
      end
    end
    r.ram_enabled  = ram_en_q;
    r.ram_bank_sel = ram_bank_q;
    r.mode_sel     = mode_q;
    return r;
  endfunction

  // Send one access word; predict its result at the accepting edge
  task automatic send_access(logic op, logic [15:0] addr, logic [7:0] data);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    cpu_addr_i   <= addr;
    write_data_i <= data;
    do @(posedge clk_i); while (in_stall_o);
    mapped_q.push_back(map_access(op, addr, data));
    words_sent++;
  endtask

  // Hold off the sender until every predicted word has come back
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (mapped_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      err_count++;
      if (err_count <= ShownErrors)
        $display("tb: mismatch on %s, expected 0x%0h, got 0x%0h", name, exp_v, act_v);
    end
  endtask

  // Check each accepted result word against the oldest prediction
  always @(posedge clk_i) begin
    rbm_pkg::result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (mapped_q.size() == 0) begin
        err_count++;
        if (err_count <= ShownErrors) $display("tb: result word with none predicted");
      end else begin
        e = mapped_q.pop_front();
        check_field("source", e.source, source_o);
        check_field("rom_addr", e.rom_addr, rom_addr_o);
        check_field("ram_enabled", e.ram_enabled, ram_enabled_o);
        check_field("ram_bank_sel", e.ram_bank_sel, ram_bank_sel_o);
        check_field("mode_sel", e.mode_sel, mode_sel_o);
        words_checked++;
      end
    end
  end

  // Decode of every region straight out of reset, overlay active
  task automatic test_reset_decode();
    send_access(rbm_pkg::OpRead, 16'h0000, 8'hFF);
    send_access(rbm_pkg::OpRead, 16'h00FF, 8'h00);
    send_access(rbm_pkg::OpRead, 16'h0100, 8'h5A);
    send_access(rbm_pkg::OpRead, 16'h3FFF, 8'h00);
    send_access(rbm_pkg::OpRead, 16'h4000, 8'h00);
    send_access(rbm_pkg::OpRead, 16'h7FFF, 8'hA5);
    send_access(rbm_pkg::OpRead, 16'h8000, 8'h00);
    send_access(rbm_pkg::OpRead, 16'hFFFF, 8'hFF);
  endtask

  // Each register window, the zero bank bump and both banking modes
  task automatic test_bank_registers();
    send_access(rbm_pkg::OpWrite, 16'h0000, 8'h0A);
    send_access(rbm_pkg::OpWrite, 16'h1FFF, 8'hA5);
    send_access(rbm_pkg::OpWrite, 16'h2000, 8'h00);
    send_access(rbm_pkg::OpWrite, 16'h3FFF, 8'h1F);
    send_access(rbm_pkg::OpWrite, 16'h4000, 8'h03);
    send_access(rbm_pkg::OpRead,  16'h7FFF, 8'h00);
    send_access(rbm_pkg::OpWrite, 16'h2000, 8'h20);
    send_access(rbm_pkg::OpRead,  16'h4000, 8'h00);
    send_access(rbm_pkg::OpWrite, 16'h6000, 8'h01);
    send_access(rbm_pkg::OpWrite, 16'h5FFF, 8'hFE);
    send_access(rbm_pkg::OpWrite, 16'h7FFF, 8'hFE);
    send_access(rbm_pkg::OpWrite, 16'h8000, 8'hFF);
  endtask

  // Drop the overlay, then read the former boot region
  task automatic test_boot_overlay_off();
    send_access(rbm_pkg::OpWrite, rbm_pkg::BootOffAddr, 8'h00);
    send_access(rbm_pkg::OpRead,  16'h0000, 8'h00);
    send_access(rbm_pkg::OpRead,  16'h00FF, 8'h00);
  endtask

  // Mostly bank register writes and ROM reads with random content
  task automatic test_random_traffic(int count, bit allow_boot_off);
    int          kind;
    logic        op;
    logic [15:0] addr;
    logic [7:0]  data;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      data = 8'($urandom_range(0, 255));
      if (kind < 35) begin
        op   = rbm_pkg::OpWrite;
        addr = 16'($urandom_range(0, 16'h7FFF));
        if ($urandom_range(0, 3) == 0) data[3:0] = rbm_pkg::RamEnKey;
        if ($urandom_range(0, 7) == 0) data[4:0] = 5'd0;
      end else if (kind < 70) begin
        op   = rbm_pkg::OpRead;
        addr = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 16'h01FF))
                                           : 16'($urandom_range(0, 16'h7FFF));
      end else if (kind < 85) begin
        op   = rbm_pkg::OpRead;
        addr = 16'($urandom_range(0, 16'hFFFF));
      end else if (kind < 95) begin
        op   = rbm_pkg::OpWrite;
        addr = 16'($urandom_range(0, 16'hFFFF));
      end else begin
        op   = rbm_pkg::OpWrite;
        addr = rbm_pkg::BootOffAddr;
      end
      // Keep the overlay alive for this phase
      if (!allow_boot_off && op == rbm_pkg::OpWrite && addr == rbm_pkg::BootOffAddr) begin
        op   = rbm_pkg::OpRead;
        addr = 16'($urandom_range(0, 16'h00FF));
      end
      send_access(op, addr, data);
    end
  endtask

  initial begin
    reset_mapper();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 22;
    stall_pct     = 60;
    test_reset_decode();
    test_bank_registers();
    test_random_traffic(180, 1'b0);
    wait_all_results();
    test_boot_overlay_off();

    send_idle_pct = 60;
    stall_pct     = 22;
    test_random_traffic(180, 1'b1);
    wait_all_results();

    send_idle_pct = 0;
    stall_pct     = 0;
    test_random_traffic(190, 1'b1);
    wait_all_results();
    repeat (5) @(posedge clk_i);

    $display("tb: %0d bus accesses sent, %0d result words checked", words_sent, words_checked);
    $display("tb: covered reset decode, bank windows, overlay end, three idle profiles");
    if (err_count == 0 && mapped_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", err_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/rbm_pkg.sv
rtl/core/rbm_bank_ctrl.sv
rtl/core/rbm_out_reg.sv
rtl/core/rom_bank_mapper_with_boot_overlay_core.sv
dv/rom_bank_mapper_with_boot_overlay_core_tb.sv
